@@ sv/assert_macros.svh @@
// Assertion macros used by the particle pool engine top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ sv/ppue_pkg.sv @@
// Package with shared types and constants of the particle pool engine.
package ppue_pkg;
	localparam logic [1:0] KIND_EMIT = 2'd0;
	localparam logic [1:0] KIND_REPORT = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;
	localparam logic ACT_EMIT = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam logic [15:0] DRAG_RESET = 16'd62259;
	localparam logic [7:0] CUTOFF_RESET = 8'd5;
	localparam logic CFG_DRAG = 1'b0;
	localparam logic CFG_CUTOFF = 1'b1;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [23:0] life;
	} particle_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] slot;
		logic replaced;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
		logic [7:0] alpha;
		logic [6:0] active_count;
		logic last;
	} result_t;
endpackage

@@ sv/ppue_store.sv @@
// Synchronous particle memory with one write and one registered read port.
module ppue_store #(
	parameter int SLOTS = 32,
	parameter int AW = 5
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input ppue_pkg::particle_t wdata,
	input logic [AW-1:0] raddr,
	output ppue_pkg::particle_t rdata
);
	ppue_pkg::particle_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/ppue_update.sv @@
// Pipelined tick arithmetic: advance, drag and fade for one particle.
module ppue_update (
	input logic clk,
	input ppue_pkg::particle_t p_in,
	input logic [19:0] dt,
	input logic [15:0] drag,
	output ppue_pkg::particle_t p_out,
	output logic [7:0] alpha_s2
);
	logic signed [52:0] dx_s1, dy_s1, dz_s1;
	logic signed [48:0] gx_s1, gy_s1, gz_s1;
	ppue_pkg::particle_t p_s1;
	logic [31:0] la;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
			input logic signed [52:0] m);
		logic signed [52:0] d;
		logic signed [53:0] s;
		begin
			d = (m < 0) ? -((-m) >>> 16) : (m >>> 16);
			s = 54'(p) + 54'(d);
			if (s > 54'sd2147483647) sat_add = 32'sh7FFFFFFF;
			else if (s < -54'sd2147483648) sat_add = 32'sh80000000;
			else sat_add = s[31:0];
		end
	endfunction

	function automatic logic signed [31:0] trunc16(input logic signed [48:0] m);
		logic signed [48:0] d;
		begin
			d = (m < 0) ? -((-m) >>> 16) : (m >>> 16);
			trunc16 = d[31:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		dx_s1 <= p_in.vx * $signed({1'b0, dt});
		dy_s1 <= p_in.vy * $signed({1'b0, dt});
		dz_s1 <= p_in.vz * $signed({1'b0, dt});
		gx_s1 <= p_in.vx * $signed({1'b0, drag});
		gy_s1 <= p_in.vy * $signed({1'b0, drag});
		gz_s1 <= p_in.vz * $signed({1'b0, drag});
		p_s1 <= {p_in.px, p_in.py, p_in.pz, p_in.vx, p_in.vy, p_in.vz,
			p_in.life - 24'(dt)};
	end

	assign la = ({8'd0, p_s1.life} * 32'd255) >> 16;

	always_comb begin
		p_out.px = sat_add(p_s1.px, dx_s1);
		p_out.py = sat_add(p_s1.py, dy_s1);
		p_out.pz = sat_add(p_s1.pz, dz_s1);
		p_out.vx = trunc16(gx_s1);
		p_out.vy = trunc16(gy_s1);
		p_out.vz = trunc16(gz_s1);
		p_out.life = p_s1.life;
		alpha_s2 = (la > 32'd255) ? 8'd255 : la[7:0];
	end
endmodule

@@ sv/particle_pool_update_engine_unit.sv @@
// Top level of the particle pool engine: control, valid bits and output register.
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | action, pos_*, vel_*, life_seconds, time_step
// out     | output    | out_valid/out_stall| kind, slot, replaced, new_*, alpha, ...
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// An emit passes through ST_EMIT. A tick steps every slot through ST_READ, ST_CALC
// and ST_WRITE, set by the read, update and write of one memory, then ends in ST_SUM.
// Reset clears valid bits, next slot pointer, counters and output register and sets
// drag and cutoff to defaults. A stalled output word holds the sequencer until it is taken.
`include "assert_macros.svh"
module particle_pool_update_engine_unit #(
	parameter int PARTICLE_SLOTS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic action,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] vel_y,
	input logic signed [31:0] vel_z,
	input logic [23:0] life_seconds,
	input logic [19:0] time_step,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [5:0] slot,
	output logic replaced,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_z,
	output logic [7:0] alpha,
	output logic [6:0] active_count,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	localparam int AW = $clog2(PARTICLE_SLOTS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EMIT = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;
	localparam logic [2:0] ST_SUM = 3'd5;

	logic [2:0] state_q;
	logic [PARTICLE_SLOTS-1:0] alive_q;
	logic [AW-1:0] next_q, idx_q;
	logic [15:0] drag_q;
	logic [7:0] cutoff_q;
	logic [19:0] dt_q;
	logic [6:0] count_q;
	ppue_pkg::particle_t emit_q, rdata, upd;
	logic [7:0] upd_alpha;
	logic out_full_q;
	ppue_pkg::result_t res_q, res_d;
	logic out_load;
	logic we;
	logic [AW-1:0] waddr;
	ppue_pkg::particle_t wdata;
	logic [AW-1:0] free_idx;
	logic free_found;
	logic [AW-1:0] cand;
	logic [AW:0] cand_sum;
	logic out_free, dies;

	ppue_store #(.SLOTS(PARTICLE_SLOTS), .AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(idx_q), .rdata(rdata)
	);

	ppue_update u_update (
		.clk(clk), .p_in(rdata), .dt(dt_q), .drag(drag_q),
		.p_out(upd), .alpha_s2(upd_alpha)
	);

	always_comb begin
		free_found = 1'b0;
		free_idx = next_q;
		cand_sum = '0;
		cand = next_q;
		for (int i = PARTICLE_SLOTS - 1; i >= 0; i--) begin
			cand_sum = {1'b0, next_q} + (AW+1)'(i);
			cand = (cand_sum >= (AW+1)'(PARTICLE_SLOTS)) ?
				AW'(cand_sum - (AW+1)'(PARTICLE_SLOTS)) : AW'(cand_sum);
			if (!alive_q[cand]) begin
				free_found = 1'b1;
				free_idx = cand;
			end
		end
	end

	assign out_free = !out_full_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign dies = (rdata.life <= 24'(dt_q)) || (upd_alpha < cutoff_q);
	assign we = (state_q == ST_EMIT) ||
		(state_q == ST_WRITE && alive_q[idx_q] && !dies && out_free);
	assign waddr = (state_q == ST_EMIT) ? free_idx : idx_q;
	assign wdata = (state_q == ST_EMIT) ? emit_q : upd;

	always_comb begin
		out_load = 1'b0;
		res_d = '0;
		case (state_q)
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					res_d.kind = ppue_pkg::KIND_EMIT;
					res_d.slot = 6'(free_idx);
					res_d.replaced = !free_found;
					res_d.last = 1'b1;
				end
			end
			ST_WRITE: begin
				if (alive_q[idx_q] && !dies && out_free) begin
					out_load = 1'b1;
					res_d.kind = ppue_pkg::KIND_REPORT;
					res_d.slot = 6'(idx_q);
					res_d.new_x = upd.px;
					res_d.new_y = upd.py;
					res_d.new_z = upd.pz;
					res_d.alpha = upd_alpha;
				end
			end
			ST_SUM: begin
				if (out_free) begin
					out_load = 1'b1;
					res_d.kind = ppue_pkg::KIND_SUMMARY;
					res_d.active_count = count_q;
					res_d.last = 1'b1;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			alive_q <= '0;
			next_q <= '0;
			idx_q <= '0;
			drag_q <= ppue_pkg::DRAG_RESET;
			cutoff_q <= ppue_pkg::CUTOFF_RESET;
			count_q <= '0;
			out_full_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == ppue_pkg::CFG_DRAG) drag_q <= cfg_data;
				else cutoff_q <= cfg_data[7:0];
			end
			if (out_load) out_full_q <= 1'b1;
			else if (!out_stall) out_full_q <= 1'b0;
			if (out_load) res_q <= res_d;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (action == ppue_pkg::ACT_EMIT) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_READ;
							idx_q <= '0;
							count_q <= '0;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						alive_q[free_idx] <= 1'b1;
						next_q <= (32'(free_idx) == PARTICLE_SLOTS - 1) ? '0 :
							free_idx + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_WRITE;
				ST_WRITE: begin
					if (!alive_q[idx_q]) begin
						state_q <= (32'(idx_q) == PARTICLE_SLOTS - 1) ? ST_SUM : ST_READ;
						idx_q <= idx_q + 1'b1;
					end else if (dies) begin
						alive_q[idx_q] <= 1'b0;
						state_q <= (32'(idx_q) == PARTICLE_SLOTS - 1) ? ST_SUM : ST_READ;
						idx_q <= idx_q + 1'b1;
					end else if (out_free) begin
						count_q <= count_q + 1'b1;
						state_q <= (32'(idx_q) == PARTICLE_SLOTS - 1) ? ST_SUM : ST_READ;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_CALC;
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			emit_q <= {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, life_seconds};
			if (action == ppue_pkg::ACT_TICK) dt_q <= time_step;
		end
	end

	assign out_valid = out_full_q;
	assign kind = res_q.kind;
	assign slot = res_q.slot;
	assign replaced = res_q.replaced;
	assign new_x = res_q.new_x;
	assign new_y = res_q.new_y;
	assign new_z = res_q.new_z;
	assign alpha = res_q.alpha;
	assign active_count = res_q.active_count;
	assign last = res_q.last;

	`ASSERT_IMPL(a_busy_stalls, clk, arst_n, state_q != ST_IDLE, in_stall)
	`ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, 32'(count_q) <= PARTICLE_SLOTS)
	`ASSERT_NEXT(a_emit_alive, clk, arst_n, state_q == ST_EMIT && out_free,
		alive_q[$past(free_idx)])
endmodule
